FILE: rtl/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the LCD decimal number writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  localparam int DEFAULT_MAX_DIGITS = 8;
  localparam int DEFAULT_FIFO_DEPTH = 2;

  localparam int BIN_W        = 32;
  localparam int BCD_DIGITS   = 10;
  localparam int SHOWN_DIGITS = 8;
  localparam int DIG_IDX_W    = $clog2(SHOWN_DIGITS);
  localparam int CNT_W        = 4;
  localparam int BITCNT_W     = $clog2(BIN_W);

  localparam logic [7:0] ROW1_BASE  = 8'h80;
  localparam logic [7:0] ROW2_BASE  = 8'hC0;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [1:0] ROW_FIRST  = 2'd1;

  typedef struct packed {
    logic [1:0]  row;
    logic [5:0]  column;
    logic [31:0] number;
    logic [3:0]  digit_count;
  } request_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]                        addr;
    logic [CNT_W-1:0]                  count;
    logic [SHOWN_DIGITS-1:0][3:0]      digits;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ADDR,
    B_DATA
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/lcdw_front.sv
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts a request, converts the number to BCD bit-serially and queues a job.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_front #(
  parameter int MAX_DIGITS = lcdw_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  lcdw_pkg::request_t request,
  output logic              busy,
  output logic              push,
  output lcdw_pkg::job_t    job,
  input  wire               full
);
  import lcdw_pkg::*;

  front_state_t state, state_next;

  logic [BIN_W-1:0]            bin;
  logic [BCD_DIGITS-1:0][3:0]  bcd;
  logic [BCD_DIGITS-1:0][3:0]  bcd_adj;
  logic [BITCNT_W-1:0]         bit_cnt;
  logic [7:0]                  addr;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_sat;
  logic [7:0]                  base;

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  always_comb begin
    if ({1'b0, request.digit_count} > (CNT_W+1)'(MAX_DIGITS)) begin
      count_sat = CNT_W'(MAX_DIGITS);
    end else begin
      count_sat = request.digit_count;
    end
    base = ((request.row == ROW_FIRST) ? ROW1_BASE : ROW2_BASE) | {2'b00, request.column};
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (start) state_next = F_CONV;
      F_CONV: if (bit_cnt == BITCNT_W'(BIN_W - 1)) state_next = F_PUSH;
      F_PUSH: if (count == '0 || !full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != F_IDLE);
    push        = (state == F_PUSH) && (count != '0) && !full;
    job.addr    = addr;
    job.count   = count;
    job.digits  = bcd[SHOWN_DIGITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      bin     <= request.number;
      bcd     <= '0;
      bit_cnt <= '0;
      addr    <= base - 8'd1;
      count   <= count_sat;
    end else if (state == F_CONV) begin
      {bcd, bin} <= {bcd_adj[BCD_DIGITS-1:0], bin} << 1;
      bit_cnt    <= bit_cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcdw_fifo.sv
// ----------------------------------------------------------------------------
// lcdw_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_fifo #(
  parameter int DEPTH = lcdw_pkg::DEFAULT_FIFO_DEPTH
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  lcdw_pkg::job_t  wdata,
  output logic            full,
  input  wire             pop,
  output lcdw_pkg::job_t  rdata,
  output logic            empty
);
  import lcdw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  job_t mem [DEPTH];

  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FILL_W-1:0] fill;

  always_comb begin
    full  = (fill == FILL_W'(DEPTH));
    empty = (fill == '0);
    rdata = mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcdw_back.sv
// ----------------------------------------------------------------------------
// lcdw_back
// Emits the address and data byte pairs of one job, one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              empty,
  input  lcdw_pkg::job_t   job,
  output logic             pop,
  output logic             strobe,
  output lcdw_pkg::result_t result
);
  import lcdw_pkg::*;

  back_state_t state, state_next;

  logic [7:0]                   addr;
  logic [CNT_W-1:0]             idx;
  logic [SHOWN_DIGITS-1:0][3:0] digits;
  logic [3:0]                   digit;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!empty) state_next = B_ADDR;
      B_ADDR: state_next = B_DATA;
      B_DATA: state_next = (idx == '0) ? B_IDLE : B_ADDR;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    digit = (idx < CNT_W'(SHOWN_DIGITS)) ? digits[idx[DIG_IDX_W-1:0]] : 4'd0;
    pop   = (state == B_IDLE) && !empty;
    strobe = (state != B_IDLE);
    result.is_data  = (state == B_DATA);
    result.last     = (state == B_DATA) && (idx == '0);
    result.lcd_byte = (state == B_DATA) ? (ASCII_ZERO | {4'd0, digit}) : addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr   <= job.addr;
      idx    <= job.count - 1'b1;
      digits <= job.digits;
    end else if (state == B_DATA) begin
      addr <= addr + 8'd1;
      idx  <= idx - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcd_decimal_number_writer.sv
// ----------------------------------------------------------------------------
// lcd_decimal_number_writer
// Turns a row/column/number/count request into character-LCD address and
// data words, most significant shown digit first.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The front converts
// the number to decimal one bit per cycle; busy stays high through the
// conversion and the queue push, longer only while the two-entry job queue
// is full. The back then emits 2*n words for n shown digits, one per cycle,
// passing through its idle state before each job; it runs while the front
// converts the next request. Each word is on result for exactly one cycle
// with strobe high and must be taken then. A count of zero emits nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_decimal_number_writer #(
  parameter int MAX_DIGITS = lcdw_pkg::DEFAULT_MAX_DIGITS,
  parameter int FIFO_DEPTH = lcdw_pkg::DEFAULT_FIFO_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  lcdw_pkg::request_t request,
  output logic               busy,
  output logic               strobe,
  output lcdw_pkg::result_t  result
);
  import lcdw_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t job_in;
  job_t job_out;

  lcdw_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .push    (push),
    .job     (job_in),
    .full    (full)
  );

  lcdw_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .rdata (job_out),
    .empty (empty)
  );

  lcdw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .job    (job_out),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: test/lcd_decimal_number_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_writer_checker
// Watches the request and result channels of the LCD decimal number writer.
// Each accepted request is expanded into the address/data words it should
// produce. Every strobed word is compared field by field with the oldest
// word still owed.
// ----------------------------------------------------------------------------

module lcd_writer_checker
  import lcdw_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  wire      clk,
  input  wire      rst,
  input  wire      start,
  input  wire      busy,
  input  request_t request,
  input  wire      strobe,
  input  result_t  result,
  output int       mismatches,
  output int       words_pending
);

  result_t lcd_words_q[$];

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // address word then ASCII word per shown digit, most significant first
  function automatic void predict_words(input request_t req);
    logic [31:0] shown;
    logic [3:0]  digit [0:BCD_DIGITS-1];
    logic [7:0]  base_addr;
    int          n;
    result_t     w;
    shown = req.number % 32'd100000000;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      digit[k] = 4'(shown % 10);
      shown    = shown / 10;
    end
    n = (int'(req.digit_count) > MAX_DIGITS) ? MAX_DIGITS : int'(req.digit_count);
    base_addr = ((req.row == ROW_FIRST) ? ROW1_BASE : ROW2_BASE) | {2'b00, req.column};
    for (int i = 0; i < n; i++) begin
      w.lcd_byte = base_addr + 8'(i) - 8'd1;
      w.is_data  = 1'b0;
      w.last     = 1'b0;
      lcd_words_q.push_back(w);
      w.lcd_byte = ASCII_ZERO + {4'h0, digit[n - 1 - i]};
      w.is_data  = 1'b1;
      w.last     = (i == n - 1);
      lcd_words_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (strobe) begin
        if (lcd_words_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0h", result));
        end else begin
          want = lcd_words_q.pop_front();
          if (result.lcd_byte !== want.lcd_byte)
            report_mismatch($sformatf("lcd_byte got %0h want %0h",
                                      result.lcd_byte, want.lcd_byte));
          if (result.is_data !== want.is_data)
            report_mismatch($sformatf("is_data got %0b want %0b (byte %0h)",
                                      result.is_data, want.is_data, want.lcd_byte));
          if (result.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b (byte %0h)",
                                      result.last, want.last, want.lcd_byte));
        end
      end
      if (start && !busy)
        predict_words(request);
    end
    words_pending = lcd_words_q.size();
  end

endmodule

FILE: test/lcd_decimal_number_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_decimal_number_writer_tb
// Drives display requests into the LCD decimal number writer: a directed set
// covering field extremes, zero and saturating counts, address wrap and every
// row code, then random requests with random start gaps. The checker beside
// the block predicts and compares every word.
// ----------------------------------------------------------------------------

module lcd_decimal_number_writer_tb;
  import lcdw_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     strobe;
  result_t  result;
  int       mismatches;
  int       words_pending;
  bit       no_gaps;

  lcd_decimal_number_writer dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
  );

  lcd_writer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .strobe        (strobe),
    .result        (result),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic issue(input logic [1:0] row, input logic [5:0] column,
                       input logic [31:0] number, input logic [3:0] digit_count);
    request_t req;
    req.row         = row;
    req.column      = column;
    req.number      = number;
    req.digit_count = digit_count;
    request <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    if (!no_gaps && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] num;
    logic [5:0]  col;
    logic [3:0]  cnt;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    no_gaps  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    issue(2'd1, 6'd1,  32'd12345678,  4'd8);
    issue(2'd2, 6'd1,  32'd0,         4'd1);
    issue(2'd0, 6'd0,  32'hFFFFFFFF,  4'd15);
    issue(2'd3, 6'd63, 32'd99999999,  4'd8);   // address wraps past 0xFF
    issue(2'd1, 6'd40, 32'd100000000, 4'd9);
    issue(2'd2, 6'd5,  32'd7,         4'd0);
    issue(2'd0, 6'd9,  32'd7,         4'd0);
    issue(2'd1, 6'd63, 32'hAAAAAAAA,  4'd4);
    issue(2'd0, 6'd21, 32'h55555555,  4'd10);
    issue(2'd1, 6'd0,  32'd1,         4'd2);
    issue(2'd2, 6'd2,  32'd123,       4'd8);   // leading zeros
    issue(2'd1, 6'd16, 32'd987654321, 4'd12);
    issue(2'd3, 6'd40, 32'd199999999, 4'd3);
    issue(2'd2, 6'd32, 32'h80000000,  4'd7);

    for (int k = 0; k < 136; k++) begin
      no_gaps = (k >= 45 && k < 90);
      case ($urandom_range(0, 3))
        0: num = $urandom;
        1: num = $urandom_range(0, 99999999);
        2: num = $urandom_range(0, 999);
        default: num = 32'd100000000 * $urandom_range(0, 42) + $urandom_range(0, 9);
      endcase
      col = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 40)) : 6'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0: cnt = 4'd0;
        1: cnt = 4'($urandom_range(9, 15));
        default: cnt = 4'($urandom_range(1, 8));
      endcase
      issue(2'($urandom_range(0, 3)), col, num, cnt);
    end
    start <= 1'b0;

    repeat (2) @(posedge clk);
    wait (words_pending == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lcdw_pkg.sv
rtl/lcdw_front.sv
rtl/lcdw_fifo.sv
rtl/lcdw_back.sv
rtl/lcd_decimal_number_writer.sv
test/lcd_decimal_number_writer_checker.sv
test/lcd_decimal_number_writer_tb.sv
